// ===== sv/qxm_pkg.sv =====
// ----------------------------------------------------------------------------
// qxm_pkg: shared types and constants of the quad X motor mixer
// Widths, register indexes, mode codes, PWM limits and the result struct.
// ----------------------------------------------------------------------------
package qxm_pkg;

  // raw channel width
  localparam int RC_BITS   = 11;
  localparam int PWM_BITS  = 10;
  localparam int GAIN_BITS = 8;
  // signed multiplicand width: holds a PWM difference or a gain
  localparam int MW        = ((PWM_BITS > GAIN_BITS) ? PWM_BITS : GAIN_BITS) + 1;
  // magnitude bits of a product, also quotient bits
  localparam int QW        = RC_BITS + MW - 1;
  // mul stage, abs stage, one stage per quotient bit
  localparam int NSTG      = QW + 2;

  // configuration register indexes
  localparam int CFG_AW = 3;
  localparam logic [CFG_AW-1:0] CFG_RC_LOW    = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_RC_MID    = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_RC_HIGH   = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_BASE_FLR  = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_BASE_CEIL = 3'd4;
  localparam logic [CFG_AW-1:0] CFG_GAIN_NORM = 3'd5;
  localparam logic [CFG_AW-1:0] CFG_GAIN_FINE = 3'd6;

  // mode codes
  localparam logic [1:0] MODE_NORMAL  = 2'd0;
  localparam logic [1:0] MODE_FINE    = 2'd1;
  localparam logic [1:0] MODE_UNKNOWN = 2'd2;

  // mode switch windows
  localparam logic [RC_BITS-1:0] MODE_NORM_LO = RC_BITS'(800);
  localparam logic [RC_BITS-1:0] MODE_NORM_HI = RC_BITS'(1200);
  localparam logic [RC_BITS-1:0] MODE_FINE_LO = RC_BITS'(1250);
  localparam logic [RC_BITS-1:0] MODE_FINE_HI = RC_BITS'(1500);

  // motor limits
  localparam int PWM_MIN = 150;
  localparam int PWM_MAX = 600;

  // merged result of one frame
  typedef struct packed {
    logic [PWM_BITS-1:0] motor_fl;
    logic [PWM_BITS-1:0] motor_fr;
    logic [PWM_BITS-1:0] motor_rr;
    logic [PWM_BITS-1:0] motor_rl;
    logic [PWM_BITS-1:0] base;
  } mix_res_t;

endpackage

// ===== sv/qxm_if.sv =====
// ----------------------------------------------------------------------------
// qxm_in_if / qxm_out_if: frame and result channels
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface qxm_in_if import qxm_pkg::*;;
  logic               valid;
  logic               ready;
  logic [RC_BITS-1:0] roll_raw;
  logic [RC_BITS-1:0] pitch_raw;
  logic [RC_BITS-1:0] throttle_raw;
  logic [RC_BITS-1:0] yaw_raw;
  logic [RC_BITS-1:0] mode_raw;
  logic               frame_ok;

  modport source (output valid, roll_raw, pitch_raw, throttle_raw, yaw_raw, mode_raw,
                  frame_ok, input ready);
  modport sink   (input valid, roll_raw, pitch_raw, throttle_raw, yaw_raw, mode_raw,
                  frame_ok, output ready);
endinterface

interface qxm_out_if import qxm_pkg::*;;
  logic                valid;
  logic                ready;
  logic [PWM_BITS-1:0] motor_front_left;
  logic [PWM_BITS-1:0] motor_front_right;
  logic [PWM_BITS-1:0] motor_rear_right;
  logic [PWM_BITS-1:0] motor_rear_left;
  logic [PWM_BITS-1:0] base_level;
  logic [1:0]          mode_code;

  modport source (output valid, motor_front_left, motor_front_right, motor_rear_right,
                  motor_rear_left, base_level, mode_code, input ready);
  modport sink   (input valid, motor_front_left, motor_front_right, motor_rear_right,
                  motor_rear_left, base_level, mode_code, output ready);
endinterface

// ===== sv/qxm_lane.sv =====
// ----------------------------------------------------------------------------
// qxm_lane: scaled ratio lane
// Computes trunc(a*b/den) toward zero, zero when den is zero. One multiply
// stage, one sign/magnitude stage, then a restoring divider pipelined one
// quotient bit per stage. All stages advance together on en.
// ----------------------------------------------------------------------------
module qxm_lane import qxm_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [RC_BITS:0]  a_i,
  input  logic signed [MW-1:0]     b_i,
  input  logic signed [RC_BITS:0]  den_i,
  output logic signed [QW:0]       q_o
);

  // multiply stage
  logic signed [QW:0]      prod_r;
  logic signed [RC_BITS:0] den_r;

  // divider stages; index 0 is the sign/magnitude stage
  logic [RC_BITS-1:0] rem_r [QW+1];
  logic [QW-1:0]      quo_r [QW+1];
  logic [QW-1:0]      num_r [QW+1];
  logic [RC_BITS-1:0] dvs_r [QW+1];
  logic               neg_r [QW+1];
  logic               dz_r  [QW+1];

  logic [QW:0]        prod_abs;
  logic [RC_BITS:0]   den_abs;
  logic [RC_BITS:0]   trial   [QW];
  logic               ge      [QW];
  logic [RC_BITS-1:0] rem_nxt [QW];
  logic [QW-1:0]      quo_nxt [QW];

  // magnitudes
  always_comb begin
    prod_abs = prod_r[QW] ? (-prod_r) : prod_r;
    den_abs  = den_r[RC_BITS] ? (-den_r) : den_r;
  end

  // one quotient bit per stage
  always_comb begin
    for (int k = 0; k < QW; k++) begin
      trial[k]   = {rem_r[k], num_r[k][QW-1-k]};
      ge[k]      = (trial[k] >= {1'b0, dvs_r[k]});
      rem_nxt[k] = ge[k] ? RC_BITS'(trial[k] - {1'b0, dvs_r[k]}) : trial[k][RC_BITS-1:0];
      quo_nxt[k] = {quo_r[k][QW-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r   <= a_i * b_i;
      den_r    <= den_i;
      rem_r[0] <= '0;
      quo_r[0] <= '0;
      num_r[0] <= prod_abs[QW-1:0];
      dvs_r[0] <= den_abs[RC_BITS-1:0];
      neg_r[0] <= prod_r[QW] ^ den_r[RC_BITS];
      dz_r[0]  <= (den_r == '0);
      for (int k = 0; k < QW; k++) begin
        rem_r[k+1] <= rem_nxt[k];
        quo_r[k+1] <= quo_nxt[k];
        num_r[k+1] <= num_r[k];
        dvs_r[k+1] <= dvs_r[k];
        neg_r[k+1] <= neg_r[k];
        dz_r[k+1]  <= dz_r[k];
      end
    end
  end

  // signed quotient
  always_comb begin
    if (dz_r[QW]) begin
      q_o = '0;
    end else if (neg_r[QW]) begin
      q_o = -$signed({1'b0, quo_r[QW]});
    end else begin
      q_o = $signed({1'b0, quo_r[QW]});
    end
  end

endmodule

// ===== sv/qxm_merge.sv =====
// ----------------------------------------------------------------------------
// qxm_merge: base level and X-frame mix
// Adds the throttle lane to the floor, saturates, then mixes the axis lanes
// into four motor values clamped to the PWM window.
// ----------------------------------------------------------------------------
module qxm_merge import qxm_pkg::*; (
  input  logic [PWM_BITS-1:0]  base_floor_i,
  input  logic signed [QW:0]   thr_q_i,
  input  logic signed [QW:0]   roll_q_i,
  input  logic signed [QW:0]   pitch_q_i,
  input  logic signed [QW:0]   yaw_q_i,
  output mix_res_t             res_o
);

  localparam int SW = QW + 4;

  logic signed [SW-1:0]  base_s;
  logic [PWM_BITS-1:0]   base_sat;
  logic signed [SW-1:0]  b, r, p, y;
  logic signed [SW-1:0]  fl, fr, rr, rl;

  function automatic logic [PWM_BITS-1:0] clamp_m(input logic signed [SW-1:0] x);
    logic [PWM_BITS-1:0] v;
    if (x < SW'(PWM_MIN)) v = PWM_BITS'(PWM_MIN);
    else if (x > SW'(PWM_MAX)) v = PWM_BITS'(PWM_MAX);
    else v = x[PWM_BITS-1:0];
    return v;
  endfunction

  // base with saturation to the PWM word
  always_comb begin
    base_s = $signed(SW'(base_floor_i)) + SW'(thr_q_i);
    if (base_s < 0) base_sat = '0;
    else if (base_s > SW'({PWM_BITS{1'b1}})) base_sat = '1;
    else base_sat = base_s[PWM_BITS-1:0];
  end

  // X-frame mix
  always_comb begin
    b  = $signed(SW'(base_sat));
    r  = SW'(roll_q_i);
    p  = SW'(pitch_q_i);
    y  = SW'(yaw_q_i);
    fl = b + p + r - y;
    fr = b + p - r + y;
    rr = b - p - r - y;
    rl = b - p + r + y;
    res_o.motor_fl = clamp_m(fl);
    res_o.motor_fr = clamp_m(fr);
    res_o.motor_rr = clamp_m(rr);
    res_o.motor_rl = clamp_m(rl);
    res_o.base     = base_sat;
  end

endmodule

// ===== sv/quad_x_motor_mixer.sv =====
// ----------------------------------------------------------------------------
// quad_x_motor_mixer: X-frame quadcopter motor mixer
// Four lanes (throttle, roll, pitch, yaw) scale and divide in parallel; a
// merge stage forms base level and the four clamped motor values.
// ----------------------------------------------------------------------------
// Channel | Dir | Transfer                 | Payload
// in_ch   | in  | valid & ready            | five raw channels, frame_ok
// out_ch  | out | valid & ready            | four motors, base_level, mode_code
// cfg     | in  | cfg_we at clock edge     | cfg_addr index, cfg_wdata
//
// One frame per cycle sustained while the output does not stall; frames pass
// the multiply, magnitude, 21 bit-per-stage divider stages and output register.
// Frames with frame_ok low are taken and dropped. Synchronous active-low
// reset restores the default registers and empties the pipe. A stalled
// output parks one result in a skid register; the pipe then holds.
// ----------------------------------------------------------------------------
module quad_x_motor_mixer import qxm_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  qxm_in_if.sink              in_ch,
  qxm_out_if.source           out_ch,
  input  logic                cfg_we,
  input  logic [CFG_AW-1:0]   cfg_addr,
  input  logic [RC_BITS-1:0]  cfg_wdata
);

  // configuration registers
  logic [RC_BITS-1:0]   rc_low_r, rc_mid_r, rc_high_r;
  logic [PWM_BITS-1:0]  base_floor_r, base_ceil_r;
  logic [GAIN_BITS-1:0] gain_norm_r, gain_fine_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rc_low_r     <= RC_BITS'(172);
      rc_mid_r     <= RC_BITS'(991);
      rc_high_r    <= RC_BITS'(1811);
      base_floor_r <= PWM_BITS'(205);
      base_ceil_r  <= PWM_BITS'(410);
      gain_norm_r  <= GAIN_BITS'(50);
      gain_fine_r  <= GAIN_BITS'(25);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_RC_LOW:    rc_low_r     <= cfg_wdata;
        CFG_RC_MID:    rc_mid_r     <= cfg_wdata;
        CFG_RC_HIGH:   rc_high_r    <= cfg_wdata;
        CFG_BASE_FLR:  base_floor_r <= cfg_wdata[PWM_BITS-1:0];
        CFG_BASE_CEIL: base_ceil_r  <= cfg_wdata[PWM_BITS-1:0];
        CFG_GAIN_NORM: gain_norm_r  <= cfg_wdata[GAIN_BITS-1:0];
        CFG_GAIN_FINE: gain_fine_r  <= cfg_wdata[GAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // pipe control
  logic skid_v_r, out_v_r, en;
  logic [NSTG-1:0] v_r;
  logic [1:0]      code_r [NSTG];
  logic            in_xfer;

  assign en           = !skid_v_r;
  assign in_ch.ready  = en;
  assign in_xfer      = in_ch.valid && en;

  // mode window and gain
  logic [1:0]           mode_c;
  logic [GAIN_BITS-1:0] gain;
  always_comb begin
    if (in_ch.mode_raw >= MODE_NORM_LO && in_ch.mode_raw <= MODE_NORM_HI) begin
      mode_c = MODE_NORMAL;
      gain   = gain_norm_r;
    end else if (in_ch.mode_raw >= MODE_FINE_LO && in_ch.mode_raw <= MODE_FINE_HI) begin
      mode_c = MODE_FINE;
      gain   = gain_fine_r;
    end else begin
      mode_c = MODE_UNKNOWN;
      gain   = gain_norm_r;
    end
  end

  // lane operands
  logic signed [RC_BITS:0] thr_a, thr_den, span_lo, span_hi;
  logic signed [RC_BITS:0] roll_a, pitch_a, yaw_a, roll_den, pitch_den, yaw_den;
  logic signed [MW-1:0]    thr_b, gain_b;

  always_comb begin
    thr_a    = $signed({1'b0, in_ch.throttle_raw}) - $signed({1'b0, rc_low_r});
    thr_den  = $signed({1'b0, rc_high_r}) - $signed({1'b0, rc_low_r});
    thr_b    = MW'($signed({1'b0, base_ceil_r}) - $signed({1'b0, base_floor_r}));
    gain_b   = $signed(MW'(gain));
    span_lo  = $signed({1'b0, rc_mid_r}) - $signed({1'b0, rc_low_r});
    span_hi  = $signed({1'b0, rc_high_r}) - $signed({1'b0, rc_mid_r});
    roll_a   = $signed({1'b0, in_ch.roll_raw}) - $signed({1'b0, rc_mid_r});
    pitch_a  = $signed({1'b0, in_ch.pitch_raw}) - $signed({1'b0, rc_mid_r});
    yaw_a    = $signed({1'b0, in_ch.yaw_raw}) - $signed({1'b0, rc_mid_r});
    roll_den  = roll_a[RC_BITS]  ? span_lo : span_hi;
    pitch_den = pitch_a[RC_BITS] ? span_lo : span_hi;
    yaw_den   = yaw_a[RC_BITS]   ? span_lo : span_hi;
  end

  logic signed [QW:0] thr_q, roll_q, pitch_q, yaw_q;

  qxm_lane u_thr (.clk, .en, .a_i(thr_a), .b_i(thr_b), .den_i(thr_den), .q_o(thr_q));
  qxm_lane u_roll (.clk, .en, .a_i(roll_a), .b_i(gain_b), .den_i(roll_den), .q_o(roll_q));
  qxm_lane u_pitch (.clk, .en, .a_i(pitch_a), .b_i(gain_b), .den_i(pitch_den),
                    .q_o(pitch_q));
  qxm_lane u_yaw (.clk, .en, .a_i(yaw_a), .b_i(gain_b), .den_i(yaw_den), .q_o(yaw_q));

  mix_res_t mix;
  qxm_merge u_merge (
    .base_floor_i (base_floor_r),
    .thr_q_i      (thr_q),
    .roll_q_i     (roll_q),
    .pitch_q_i    (pitch_q),
    .yaw_q_i      (yaw_q),
    .res_o        (mix)
  );

  // valid and mode code shift along with the lanes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NSTG-2:0], in_xfer && in_ch.frame_ok};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      code_r[0] <= mode_c;
      for (int k = 1; k < NSTG; k++) begin
        code_r[k] <= code_r[k-1];
      end
    end
  end

  // output register and skid
  mix_res_t   out_r, skid_r;
  logic [1:0] out_code_r, skid_code_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_ch.ready || !out_v_r) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= v_r[NSTG-1];
      end
    end else if (en && v_r[NSTG-1]) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ch.ready || !out_v_r) begin
      if (skid_v_r) begin
        out_r      <= skid_r;
        out_code_r <= skid_code_r;
      end else begin
        out_r      <= mix;
        out_code_r <= code_r[NSTG-1];
      end
    end else if (en) begin
      skid_r      <= mix;
      skid_code_r <= code_r[NSTG-1];
    end
  end

  assign out_ch.valid             = out_v_r;
  assign out_ch.motor_front_left  = out_r.motor_fl;
  assign out_ch.motor_front_right = out_r.motor_fr;
  assign out_ch.motor_rear_right  = out_r.motor_rr;
  assign out_ch.motor_rear_left   = out_r.motor_rl;
  assign out_ch.base_level        = out_r.base;
  assign out_ch.mode_code         = out_code_r;

endmodule
